// ----- hw/rtl/pcs_pkg.sv -----
`default_nettype none

package pcs_pkg;

    // Field widths that do not vary with the count or sample width.
    localparam int ACTION_BITS    = 3;
    localparam int STATUS_BITS    = 2;
    localparam int CFG_INDEX_BITS = 3;

    // Reset values of the configuration registers, in milliseconds or ADC counts.
    localparam logic [63:0] MIST_INTERVAL_RST  = 64'd420000;     // 7 minutes
    localparam logic [63:0] MIST_DURATION_RST  = 64'd30000;      // 30 seconds
    localparam logic [63:0] FLUSH_INTERVAL_RST = 64'd604800000;  // 7 days
    localparam logic [63:0] FLUSH_DURATION_RST = 64'd300000;     // 5 minutes
    localparam logic [63:0] DARK_LEVEL_RST     = 64'd2867;

    // Event codes carried by an input item.
    typedef enum logic [ACTION_BITS-1:0] {
        ACT_TICK   = 3'd0,
        ACT_LIGHT  = 3'd1,
        ACT_FLUSH  = 3'd2,
        ACT_STOP   = 3'd3,
        ACT_RESUME = 3'd4
    } pcs_action_t;

    // Answer codes for a manual flush request.
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK          = 2'd0,
        ST_REFUSE_HALT = 2'd1,
        ST_REFUSE_BUSY = 2'd2
    } pcs_status_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MIST_INTERVAL  = 3'd0,
        REG_MIST_DURATION  = 3'd1,
        REG_FLUSH_INTERVAL = 3'd2,
        REG_FLUSH_DURATION = 3'd3,
        REG_DARK_LEVEL     = 3'd4
    } pcs_reg_t;

    // Single-bit flags and status of one result item.
    typedef struct packed {
        logic        pump_on;
        logic        lamp_on;
        logic        misting_active;
        logic        flushing_active;
        logic        is_halted;
        pcs_status_t request_status;
    } pcs_flags_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pcs_if.sv -----
`default_nettype none

// Input channel: one scheduler event per item.
interface pcs_event_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                           valid;
    logic                           ready;
    logic [pcs_pkg::ACTION_BITS-1:0] action;
    logic [SAMPLE_BITS-1:0]         light_sample;

    modport source (output valid, output action, output light_sample, input ready);
    modport sink   (input valid, input action, input light_sample, output ready);
endinterface

// Output channel: one status snapshot per item.
interface pcs_result_if #(
    parameter int COUNT_BITS = 30
);
    logic                           valid;
    logic                           ready;
    logic                           pump_on;
    logic                           lamp_on;
    logic                           misting_active;
    logic                           flushing_active;
    logic                           is_halted;
    logic [pcs_pkg::STATUS_BITS-1:0] request_status;
    logic [COUNT_BITS-1:0]          mist_countdown;
    logic [COUNT_BITS-1:0]          flush_countdown;

    modport source (
        output valid, output pump_on, output lamp_on, output misting_active,
        output flushing_active, output is_halted, output request_status,
        output mist_countdown, output flush_countdown, input ready
    );
    modport sink (
        input valid, input pump_on, input lamp_on, input misting_active,
        input flushing_active, input is_halted, input request_status,
        input mist_countdown, input flush_countdown, output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/pcs_cfg_regs.sv -----
`default_nettype none

module pcs_cfg_regs #(
    parameter int COUNT_BITS  = 30,
    parameter int SAMPLE_BITS = 12,
    parameter int CFG_BITS    = 30
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [pcs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_BITS-1:0]                 cfg_data,
    output logic      [COUNT_BITS-1:0]               mist_interval,
    output logic      [COUNT_BITS-1:0]               mist_duration,
    output logic      [COUNT_BITS-1:0]               flush_interval,
    output logic      [COUNT_BITS-1:0]               flush_duration,
    output logic      [SAMPLE_BITS-1:0]              dark_level
);

    logic [COUNT_BITS-1:0]  mist_interval_reg;
    logic [COUNT_BITS-1:0]  mist_duration_reg;
    logic [COUNT_BITS-1:0]  flush_interval_reg;
    logic [COUNT_BITS-1:0]  flush_duration_reg;
    logic [SAMPLE_BITS-1:0] dark_level_reg;

    // Register file; writes to indexes past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mist_interval_reg  <= pcs_pkg::MIST_INTERVAL_RST[COUNT_BITS-1:0];
            mist_duration_reg  <= pcs_pkg::MIST_DURATION_RST[COUNT_BITS-1:0];
            flush_interval_reg <= pcs_pkg::FLUSH_INTERVAL_RST[COUNT_BITS-1:0];
            flush_duration_reg <= pcs_pkg::FLUSH_DURATION_RST[COUNT_BITS-1:0];
            dark_level_reg     <= pcs_pkg::DARK_LEVEL_RST[SAMPLE_BITS-1:0];
        end
        else if (cfg_wr_en)
        begin
            unique case (pcs_pkg::pcs_reg_t'(cfg_index))
                pcs_pkg::REG_MIST_INTERVAL:  mist_interval_reg  <= cfg_data[COUNT_BITS-1:0];
                pcs_pkg::REG_MIST_DURATION:  mist_duration_reg  <= cfg_data[COUNT_BITS-1:0];
                pcs_pkg::REG_FLUSH_INTERVAL: flush_interval_reg <= cfg_data[COUNT_BITS-1:0];
                pcs_pkg::REG_FLUSH_DURATION: flush_duration_reg <= cfg_data[COUNT_BITS-1:0];
                pcs_pkg::REG_DARK_LEVEL:     dark_level_reg     <= cfg_data[SAMPLE_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign mist_interval  = mist_interval_reg;
    assign mist_duration  = mist_duration_reg;
    assign flush_interval = flush_interval_reg;
    assign flush_duration = flush_duration_reg;
    assign dark_level     = dark_level_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/pcs_core.sv -----
`default_nettype none

module pcs_core #(
    parameter int COUNT_BITS  = 30,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              accept,
    input  wire logic [pcs_pkg::ACTION_BITS-1:0]   action,
    input  wire logic [SAMPLE_BITS-1:0]            light_sample,
    input  wire logic [COUNT_BITS-1:0]             mist_interval,
    input  wire logic [COUNT_BITS-1:0]             mist_duration,
    input  wire logic [COUNT_BITS-1:0]             flush_interval,
    input  wire logic [COUNT_BITS-1:0]             flush_duration,
    input  wire logic [SAMPLE_BITS-1:0]            dark_level,
    output pcs_pkg::pcs_flags_t                    flags,
    output logic      [COUNT_BITS-1:0]             mist_countdown,
    output logic      [COUNT_BITS-1:0]             flush_countdown
);

    logic [COUNT_BITS-1:0] mist_elapsed_reg,  mist_elapsed_next;
    logic [COUNT_BITS-1:0] flush_elapsed_reg, flush_elapsed_next;
    logic                  mist_running_reg,  mist_running_next;
    logic                  flush_running_reg, flush_running_next;
    logic                  halted_reg,        halted_next;
    logic                  lamp_reg,          lamp_next;

    logic [COUNT_BITS-1:0] mist_inc;
    logic [COUNT_BITS-1:0] flush_inc;
    logic [COUNT_BITS-1:0] mist_tick;
    logic [COUNT_BITS-1:0] flush_tick;
    logic                  flush_start;
    logic                  mist_start;
    logic                  flush_run_tick;
    logic                  mist_run_tick;
    logic [COUNT_BITS-1:0] mist_limit;
    logic [COUNT_BITS-1:0] flush_limit;
    pcs_pkg::pcs_status_t  status;

    // Scheduling decision of one tick: the flush is settled first, since a
    // running flush holds off any misting start.
    always_comb
    begin
        mist_inc       = (mist_elapsed_reg == '1) ? mist_elapsed_reg
                                                  : mist_elapsed_reg + COUNT_BITS'(1);
        flush_inc      = (flush_elapsed_reg == '1) ? flush_elapsed_reg
                                                   : flush_elapsed_reg + COUNT_BITS'(1);
        flush_start    = !flush_running_reg && (flush_inc >= flush_interval);
        flush_tick     = flush_start ? '0 : flush_inc;
        flush_run_tick = (flush_running_reg || flush_start)
                         && !(flush_tick >= flush_duration);
        mist_start     = !flush_run_tick && (mist_inc >= mist_interval);
        mist_tick      = mist_start ? '0 : mist_inc;
        mist_run_tick  = (mist_running_reg || mist_start)
                         && !(mist_tick >= mist_duration);
    end

    // Next state for the item being accepted.
    always_comb
    begin
        mist_elapsed_next  = mist_elapsed_reg;
        flush_elapsed_next = flush_elapsed_reg;
        mist_running_next  = mist_running_reg;
        flush_running_next = flush_running_reg;
        halted_next        = halted_reg;
        lamp_next          = lamp_reg;
        status             = pcs_pkg::ST_OK;
        unique case (pcs_pkg::pcs_action_t'(action))
            pcs_pkg::ACT_TICK:
            begin
                if (halted_reg)
                begin
                    mist_elapsed_next  = mist_inc;
                    flush_elapsed_next = flush_inc;
                    mist_running_next  = 1'b0;
                    flush_running_next = 1'b0;
                end
                else
                begin
                    mist_elapsed_next  = mist_tick;
                    flush_elapsed_next = flush_tick;
                    mist_running_next  = mist_run_tick;
                    flush_running_next = flush_run_tick;
                end
            end
            pcs_pkg::ACT_LIGHT:
            begin
                if (!halted_reg)
                begin
                    lamp_next = (light_sample >= dark_level);
                end
            end
            pcs_pkg::ACT_FLUSH:
            begin
                priority if (halted_reg)
                begin
                    status = pcs_pkg::ST_REFUSE_HALT;
                end
                else if (flush_running_reg || mist_running_reg)
                begin
                    status = pcs_pkg::ST_REFUSE_BUSY;
                end
                else
                begin
                    flush_running_next = 1'b1;
                    flush_elapsed_next = '0;
                end
            end
            pcs_pkg::ACT_STOP:
            begin
                halted_next        = 1'b1;
                mist_running_next  = 1'b0;
                flush_running_next = 1'b0;
                lamp_next          = 1'b0;
            end
            pcs_pkg::ACT_RESUME:
            begin
                halted_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // Countdowns show the time left in a run, or to the next start, floored at zero.
    always_comb
    begin
        mist_limit      = mist_running_next ? mist_duration : mist_interval;
        flush_limit     = flush_running_next ? flush_duration : flush_interval;
        mist_countdown  = (mist_elapsed_next >= mist_limit) ? '0
                                                            : mist_limit - mist_elapsed_next;
        flush_countdown = (flush_elapsed_next >= flush_limit) ? '0
                                                              : flush_limit - flush_elapsed_next;
    end

    // Result flags reflect the state after the update.
    always_comb
    begin
        flags.pump_on         = mist_running_next || flush_running_next;
        flags.lamp_on         = lamp_next;
        flags.misting_active  = mist_running_next;
        flags.flushing_active = flush_running_next;
        flags.is_halted       = halted_next;
        flags.request_status  = status;
    end

    // Scheduler state advances once per accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mist_elapsed_reg  <= '0;
            flush_elapsed_reg <= '0;
            mist_running_reg  <= 1'b0;
            flush_running_reg <= 1'b0;
            halted_reg        <= 1'b0;
            lamp_reg          <= 1'b0;
        end
        else if (accept)
        begin
            mist_elapsed_reg  <= mist_elapsed_next;
            flush_elapsed_reg <= flush_elapsed_next;
            mist_running_reg  <= mist_running_next;
            flush_running_reg <= flush_running_next;
            halted_reg        <= halted_next;
            lamp_reg          <= lamp_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pcs_out_reg.sv -----
`default_nettype none

module pcs_out_reg #(
    parameter int COUNT_BITS = 30
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire pcs_pkg::pcs_flags_t   flags,
    input  wire logic [COUNT_BITS-1:0] mist_countdown,
    input  wire logic [COUNT_BITS-1:0] flush_countdown,
    output logic                       can_load,
    pcs_result_if.source               results
);

    logic                  valid_reg;
    pcs_pkg::pcs_flags_t   flags_reg;
    logic [COUNT_BITS-1:0] mist_cd_reg;
    logic [COUNT_BITS-1:0] flush_cd_reg;

    // A new result may enter when the register is empty or is being emptied.
    assign can_load = !valid_reg || results.ready;

    // Valid flag of the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            flags_reg    <= flags;
            mist_cd_reg  <= mist_countdown;
            flush_cd_reg <= flush_countdown;
        end
    end

    assign results.valid           = valid_reg;
    assign results.pump_on         = flags_reg.pump_on;
    assign results.lamp_on         = flags_reg.lamp_on;
    assign results.misting_active  = flags_reg.misting_active;
    assign results.flushing_active = flags_reg.flushing_active;
    assign results.is_halted       = flags_reg.is_halted;
    assign results.request_status  = flags_reg.request_status;
    assign results.mist_countdown  = mist_cd_reg;
    assign results.flush_countdown = flush_cd_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/pump_cycle_scheduler.sv -----
// Channel   Dir  Handshake     Item contents
// events    in   valid/ready   action, light_sample
// results   out  valid/ready   pump/lamp/cycle flags, request_status, countdowns
// cfg       in   cfg_wr_en     cfg_index, cfg_data (no read-back)
//
// One item per clock while results are not stalled: the state update and countdowns
// are computed in the cycle an event is accepted, and the result appears in the next cycle.
// The result register is the only buffer; events are taken whenever it is
// empty or being read, so a stall on results stalls events in the same cycle.
// Reset is asynchronous and restores the default schedule with all cycles off.

`default_nettype none

module pump_cycle_scheduler #(
    parameter int COUNT_BITS  = 30,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    pcs_event_if.sink                               events,
    pcs_result_if.source                            results,
    input  wire logic                               cfg_wr_en,
    input  wire logic [pcs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [((COUNT_BITS > SAMPLE_BITS) ? COUNT_BITS : SAMPLE_BITS)-1:0] cfg_data
);

    localparam int CFG_BITS = (COUNT_BITS > SAMPLE_BITS) ? COUNT_BITS : SAMPLE_BITS;

    logic [COUNT_BITS-1:0]  mist_interval;
    logic [COUNT_BITS-1:0]  mist_duration;
    logic [COUNT_BITS-1:0]  flush_interval;
    logic [COUNT_BITS-1:0]  flush_duration;
    logic [SAMPLE_BITS-1:0] dark_level;
    logic                   can_load;
    logic                   accept;
    pcs_pkg::pcs_flags_t    flags;
    logic [COUNT_BITS-1:0]  mist_countdown;
    logic [COUNT_BITS-1:0]  flush_countdown;

    // Event acceptance follows the result register's room.
    assign events.ready = can_load;
    assign accept       = events.valid && can_load;

    pcs_cfg_regs #(
        .COUNT_BITS  (COUNT_BITS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CFG_BITS    (CFG_BITS)
    ) u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mist_interval  (mist_interval),
        .mist_duration  (mist_duration),
        .flush_interval (flush_interval),
        .flush_duration (flush_duration),
        .dark_level     (dark_level)
    );

    pcs_core #(
        .COUNT_BITS  (COUNT_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .action          (events.action),
        .light_sample    (events.light_sample),
        .mist_interval   (mist_interval),
        .mist_duration   (mist_duration),
        .flush_interval  (flush_interval),
        .flush_duration  (flush_duration),
        .dark_level      (dark_level),
        .flags           (flags),
        .mist_countdown  (mist_countdown),
        .flush_countdown (flush_countdown)
    );

    pcs_out_reg #(
        .COUNT_BITS (COUNT_BITS)
    ) u_out (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (accept),
        .flags           (flags),
        .mist_countdown  (mist_countdown),
        .flush_countdown (flush_countdown),
        .can_load        (can_load),
        .results         (results)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/pcs_checker.sv -----
`default_nettype none

module pcs_checker #(
    parameter int COUNT_BITS = 30
) (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             ev_valid,
    input wire logic                             ev_ready,
    input wire logic                             res_valid,
    input wire logic                             res_ready,
    input wire logic                             pump_on,
    input wire logic                             lamp_on,
    input wire logic                             misting_active,
    input wire logic                             flushing_active,
    input wire logic                             is_halted,
    input wire logic [pcs_pkg::STATUS_BITS-1:0]  request_status,
    input wire logic [COUNT_BITS-1:0]            mist_countdown,
    input wire logic [COUNT_BITS-1:0]            flush_countdown
);

    // Every accepted event yields a result in the following cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (ev_valid && ev_ready) |=> res_valid)
        else $error("accepted event produced no result");

    // An empty result register never holds off events.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> ev_ready)
        else $error("events stalled with empty result register");

    // The pump runs exactly when a cycle runs.
    a_pump_matches: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (pump_on == (misting_active || flushing_active)))
        else $error("pump drive disagrees with cycle flags");

    // While halted, pump and lamp are off.
    a_halt_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && is_halted) |-> (!pump_on && !lamp_on))
        else $error("pump or lamp on while halted");

    // A stalled result stays valid and holds its request status and countdowns.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(request_status)
            && $stable(mist_countdown) && $stable(flush_countdown)))
        else $error("stalled result changed");

endmodule

bind pump_cycle_scheduler pcs_checker #(
    .COUNT_BITS (COUNT_BITS)
) u_pcs_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .ev_valid        (events.valid),
    .ev_ready        (events.ready),
    .res_valid       (results.valid),
    .res_ready       (results.ready),
    .pump_on         (results.pump_on),
    .lamp_on         (results.lamp_on),
    .misting_active  (results.misting_active),
    .flushing_active (results.flushing_active),
    .is_halted       (results.is_halted),
    .request_status  (results.request_status),
    .mist_countdown  (results.mist_countdown),
    .flush_countdown (results.flush_countdown)
);

`default_nettype wire

// ----- tb/pump_cycle_scheduler_tb.sv -----
`default_nettype none

module pump_cycle_scheduler_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pcs_pkg::*;

    localparam int COUNT_BITS    = 30;
    localparam int SAMPLE_BITS   = 12;
    localparam int CFG_DATA_BITS = (COUNT_BITS > SAMPLE_BITS) ? COUNT_BITS : SAMPLE_BITS;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int IDLE_PCT      = 33;

    localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = '1;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

    // Action codes with no meaning; the block must leave its state alone.
    localparam logic [ACTION_BITS-1:0] ACT_SPARE_LO  = 3'd5;
    localparam logic [ACTION_BITS-1:0] ACT_SPARE_MID = 3'd6;
    localparam logic [ACTION_BITS-1:0] ACT_SPARE_HI  = 3'd7;

    typedef logic [COUNT_BITS-1:0]  count_t;
    typedef logic [SAMPLE_BITS-1:0] sample_t;

    // One status snapshot as the block reports it.
    typedef struct packed {
        pcs_flags_t flags;
        count_t     mist_left;
        count_t     flush_left;
    } snapshot_t;

    // One row of the directed event table.
    typedef struct packed {
        logic [ACTION_BITS-1:0] action;
        sample_t                sample;
        logic                   typed;
        snapshot_t              expected;
    } event_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                      cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    pcs_event_if  #(.SAMPLE_BITS(SAMPLE_BITS)) event_ch ();
    pcs_result_if #(.COUNT_BITS(COUNT_BITS))   result_ch ();

    pump_cycle_scheduler #(
        .COUNT_BITS  (COUNT_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .events    (event_ch),
        .results   (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the schedule registers.
    count_t  sched_mist_interval;
    count_t  sched_mist_duration;
    count_t  sched_flush_interval;
    count_t  sched_flush_duration;
    sample_t sched_dark_level;

    // Shadow copy of the scheduler state.
    count_t mist_elapsed;
    count_t flush_elapsed;
    logic   mist_running;
    logic   flush_running;
    logic   halted;
    logic   lamp_lit;

    snapshot_t  snapshot_q[$];
    event_row_t directed_rows[$];
    int         idle_pct;
    int         mismatches;
    int         results_checked;
    int         cycles;
    int         action_count[8];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic count_t bump(input count_t value);
        return (value == COUNT_MAX) ? value : value + count_t'(1);
    endfunction

    function automatic count_t remaining(input count_t limit, input count_t elapsed);
        return (elapsed >= limit) ? '0 : limit - elapsed;
    endfunction

    // Applies one event to the shadow state and returns the snapshot that follows it.
    task automatic schedule_event(input logic [ACTION_BITS-1:0] action, input sample_t sample,
                                  output snapshot_t snap);
        pcs_status_t status;
        status = ST_OK;
        case (action)
            ACT_TICK:
            begin
                mist_elapsed  = bump(mist_elapsed);
                flush_elapsed = bump(flush_elapsed);
                if (halted)
                begin
                    mist_running  = 1'b0;
                    flush_running = 1'b0;
                end
                else
                begin
                    // A due flush goes first and keeps misting from starting.
                    if (!flush_running && flush_elapsed >= sched_flush_interval)
                    begin
                        flush_running = 1'b1;
                        flush_elapsed = '0;
                    end
                    if (flush_running && flush_elapsed >= sched_flush_duration)
                        flush_running = 1'b0;
                    if (!flush_running && mist_elapsed >= sched_mist_interval)
                    begin
                        mist_running = 1'b1;
                        mist_elapsed = '0;
                    end
                    if (mist_running && mist_elapsed >= sched_mist_duration)
                        mist_running = 1'b0;
                end
            end
            ACT_LIGHT:
            begin
                if (!halted)
                    lamp_lit = (sample >= sched_dark_level);
            end
            ACT_FLUSH:
            begin
                if (halted)
                    status = ST_REFUSE_HALT;
                else if (flush_running || mist_running)
                    status = ST_REFUSE_BUSY;
                else
                begin
                    flush_running = 1'b1;
                    flush_elapsed = '0;
                end
            end
            ACT_STOP:
            begin
                halted        = 1'b1;
                mist_running  = 1'b0;
                flush_running = 1'b0;
                lamp_lit      = 1'b0;
            end
            ACT_RESUME:
                halted = 1'b0;
            default:
                ;
        endcase
        snap.flags.pump_on         = mist_running | flush_running;
        snap.flags.lamp_on         = lamp_lit;
        snap.flags.misting_active  = mist_running;
        snap.flags.flushing_active = flush_running;
        snap.flags.is_halted       = halted;
        snap.flags.request_status  = status;
        snap.mist_left  = mist_running ? remaining(sched_mist_duration, mist_elapsed)
                                       : remaining(sched_mist_interval, mist_elapsed);
        snap.flush_left = flush_running ? remaining(sched_flush_duration, flush_elapsed)
                                        : remaining(sched_flush_interval, flush_elapsed);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Result side: random back-pressure, changed at the falling edge.
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Compare every accepted result item with the oldest expected snapshot.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (snapshot_q.size() == 0)
            begin
                $error("result item arrived with no expected snapshot");
                mismatches++;
            end
            else
            begin
                snapshot_t want;
                want = snapshot_q.pop_front();
                results_checked++;
                check_field("pump_on", 32'(want.flags.pump_on), 32'(result_ch.pump_on));
                check_field("lamp_on", 32'(want.flags.lamp_on), 32'(result_ch.lamp_on));
                check_field("misting_active", 32'(want.flags.misting_active),
                            32'(result_ch.misting_active));
                check_field("flushing_active", 32'(want.flags.flushing_active),
                            32'(result_ch.flushing_active));
                check_field("is_halted", 32'(want.flags.is_halted),
                            32'(result_ch.is_halted));
                check_field("request_status", 32'(want.flags.request_status),
                            32'(result_ch.request_status));
                check_field("mist_countdown", 32'(want.mist_left),
                            32'(result_ch.mist_countdown));
                check_field("flush_countdown", 32'(want.flush_left),
                            32'(result_ch.flush_countdown));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d snapshots outstanding",
                     cycles, snapshot_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Offers one event item, waits for the handshake, and records what should come back.
    task automatic send_event(input logic [ACTION_BITS-1:0] action, input sample_t sample,
                              input logic typed, input snapshot_t typed_snap);
        snapshot_t predicted;
        while ($urandom_range(99) < idle_pct)
        begin
            event_ch.valid <= 1'b0;
            @(negedge clk);
        end
        event_ch.valid        <= 1'b1;
        event_ch.action       <= action;
        event_ch.light_sample <= sample;
        do
            @(posedge clk);
        while (!event_ch.ready);
        schedule_event(action, sample, predicted);
        snapshot_q.push_back(typed ? typed_snap : predicted);
        action_count[action]++;
        @(negedge clk);
    endtask

    // Random events: mostly ticks so the cycles actually run, with the rest mixed in.
    task automatic send_random_event();
        int roll;
        int sample_roll;
        logic [ACTION_BITS-1:0] action;
        roll = $urandom_range(99);
        if (roll < 68)
            action = ACT_TICK;
        else if (roll < 78)
            action = ACT_LIGHT;
        else if (roll < 86)
            action = ACT_FLUSH;
        else if (roll < 90)
            action = ACT_STOP;
        else if (roll < 96)
            action = ACT_RESUME;
        else
        begin
            roll   = $urandom_range(ACT_SPARE_HI, ACT_SPARE_LO);
            action = roll[ACTION_BITS-1:0];
        end
        sample_roll = $urandom_range(SAMPLE_MAX, 0);
        send_event(action, sample_roll[SAMPLE_BITS-1:0], 1'b0, '0);
    endtask

    // Stops offering events and waits until every result item is back.
    task automatic settle();
        event_ch.valid <= 1'b0;
        while (snapshot_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_cfg(input pcs_reg_t index, input logic [CFG_DATA_BITS-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        case (index)
            REG_MIST_INTERVAL:  sched_mist_interval  = value[COUNT_BITS-1:0];
            REG_MIST_DURATION:  sched_mist_duration  = value[COUNT_BITS-1:0];
            REG_FLUSH_INTERVAL: sched_flush_interval = value[COUNT_BITS-1:0];
            REG_FLUSH_DURATION: sched_flush_duration = value[COUNT_BITS-1:0];
            REG_DARK_LEVEL:     sched_dark_level     = value[SAMPLE_BITS-1:0];
            default:            ;
        endcase
        @(negedge clk);
    endtask

    // Writes all five registers back to back, then runs random events on that setting.
    task automatic run_phase(input count_t mist_int, input count_t mist_dur,
                             input count_t flush_int, input count_t flush_dur,
                             input sample_t dark, input int items, input int idle);
        settle();
        write_cfg(REG_MIST_INTERVAL, mist_int);
        write_cfg(REG_MIST_DURATION, mist_dur);
        write_cfg(REG_FLUSH_INTERVAL, flush_int);
        write_cfg(REG_FLUSH_DURATION, flush_dur);
        write_cfg(REG_DARK_LEVEL, {{(CFG_DATA_BITS-SAMPLE_BITS){1'b0}}, dark});
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        idle_pct = idle;
        repeat (items) send_random_event();
    endtask

    task automatic add_row(input logic [ACTION_BITS-1:0] action, input int sample,
                           input int typed, input int pump, input int lamp,
                           input int mist, input int flush, input int halt,
                           input pcs_status_t status, input int mist_left,
                           input int flush_left);
        event_row_t row;
        row.action                          = action;
        row.sample                          = sample[SAMPLE_BITS-1:0];
        row.typed                           = typed[0];
        row.expected.flags.pump_on          = pump[0];
        row.expected.flags.lamp_on          = lamp[0];
        row.expected.flags.misting_active   = mist[0];
        row.expected.flags.flushing_active  = flush[0];
        row.expected.flags.is_halted        = halt[0];
        row.expected.flags.request_status   = status;
        row.expected.mist_left              = mist_left[COUNT_BITS-1:0];
        row.expected.flush_left             = flush_left[COUNT_BITS-1:0];
        directed_rows.push_back(row);
    endtask

    initial
    begin
        event_row_t row;

        rst_n                  = 1'b0;
        cfg_wr_en             <= 1'b0;
        cfg_index             <= REG_MIST_INTERVAL;
        cfg_data              <= '0;
        event_ch.valid        <= 1'b0;
        event_ch.action       <= ACT_TICK;
        event_ch.light_sample <= '0;
        idle_pct               = IDLE_PCT;
        mismatches             = 0;
        results_checked        = 0;
        cycles                 = 0;
        foreach (action_count[i])
            action_count[i] = 0;

        // Shadow state starts at the reset schedule.
        sched_mist_interval  = MIST_INTERVAL_RST[COUNT_BITS-1:0];
        sched_mist_duration  = MIST_DURATION_RST[COUNT_BITS-1:0];
        sched_flush_interval = FLUSH_INTERVAL_RST[COUNT_BITS-1:0];
        sched_flush_duration = FLUSH_DURATION_RST[COUNT_BITS-1:0];
        sched_dark_level     = DARK_LEVEL_RST[SAMPLE_BITS-1:0];
        mist_elapsed         = '0;
        flush_elapsed        = '0;
        mist_running         = 1'b0;
        flush_running        = 1'b0;
        halted               = 1'b0;
        lamp_lit             = 1'b0;

        // Directed events on the reset schedule: the lamp threshold at its edges,
        // a manual flush accepted, refused while busy and refused while halted,
        // a light sample ignored while halted, ticks while halted, and unused codes.
        add_row(ACT_TICK,      0,    1, 0, 0, 0, 0, 0, ST_OK,          419999, 604799999);
        add_row(ACT_LIGHT,     2867, 1, 0, 1, 0, 0, 0, ST_OK,          419999, 604799999);
        add_row(ACT_LIGHT,     2866, 1, 0, 0, 0, 0, 0, ST_OK,          419999, 604799999);
        add_row(ACT_LIGHT,     4095, 1, 0, 1, 0, 0, 0, ST_OK,          419999, 604799999);
        add_row(ACT_LIGHT,     0,    1, 0, 0, 0, 0, 0, ST_OK,          419999, 604799999);
        add_row(ACT_LIGHT,     4095, 1, 0, 1, 0, 0, 0, ST_OK,          419999, 604799999);
        add_row(ACT_FLUSH,     0,    1, 1, 1, 0, 1, 0, ST_OK,          419999, 300000);
        add_row(ACT_FLUSH,     0,    1, 1, 1, 0, 1, 0, ST_REFUSE_BUSY, 419999, 300000);
        add_row(ACT_TICK,      0,    1, 1, 1, 0, 1, 0, ST_OK,          419998, 299999);
        add_row(ACT_STOP,      0,    1, 0, 0, 0, 0, 1, ST_OK,          419998, 604799999);
        add_row(ACT_FLUSH,     0,    1, 0, 0, 0, 0, 1, ST_REFUSE_HALT, 419998, 604799999);
        add_row(ACT_LIGHT,     4095, 1, 0, 0, 0, 0, 1, ST_OK,          419998, 604799999);
        add_row(ACT_TICK,      0,    1, 0, 0, 0, 0, 1, ST_OK,          419997, 604799998);
        add_row(ACT_RESUME,    0,    1, 0, 0, 0, 0, 0, ST_OK,          419997, 604799998);
        add_row(ACT_SPARE_LO,  4095, 1, 0, 0, 0, 0, 0, ST_OK,          419997, 604799998);
        add_row(ACT_SPARE_MID, 4095, 1, 0, 0, 0, 0, 0, ST_OK,          419997, 604799998);
        add_row(ACT_SPARE_HI,  4095, 1, 0, 0, 0, 0, 0, ST_OK,          419997, 604799998);
        add_row(ACT_LIGHT,     4095, 1, 0, 1, 0, 0, 0, ST_OK,          419997, 604799998);
        add_row(ACT_FLUSH,     0,    1, 1, 1, 0, 1, 0, ST_OK,          419997, 300000);
        add_row(ACT_STOP,      0,    1, 0, 0, 0, 0, 1, ST_OK,          419997, 604800000);
        add_row(ACT_RESUME,    0,    1, 0, 0, 0, 0, 0, ST_OK,          419997, 604800000);
        add_row(ACT_TICK,      1234, 0, 0, 0, 0, 0, 0, ST_OK,          0,      0);
        add_row(ACT_LIGHT,     2048, 0, 0, 0, 0, 0, 0, ST_OK,          0,      0);

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_event(row.action, row.sample, row.typed, row.expected);
        end

        // Shortest cycles everywhere and the lowest dark level.
        run_phase(count_t'(1), count_t'(1), count_t'(1), count_t'(1), sample_t'(0),
                  130, IDLE_PCT);
        // Short random cycles so that starts, ends and restarts come often.
        run_phase(count_t'($urandom_range(24, 1)), count_t'($urandom_range(16, 1)),
                  count_t'($urandom_range(80, 1)), count_t'($urandom_range(24, 1)),
                  sample_t'($urandom_range(SAMPLE_MAX, 0)), 130, IDLE_PCT);
        // Longest cycles and the highest dark level, with no idling on either side.
        run_phase(COUNT_MAX, COUNT_MAX, COUNT_MAX, COUNT_MAX, SAMPLE_MAX, 100, 0);
        run_phase(count_t'($urandom_range(24, 1)), count_t'($urandom_range(16, 1)),
                  count_t'($urandom_range(80, 1)), count_t'($urandom_range(24, 1)),
                  sample_t'($urandom_range(SAMPLE_MAX, 0)), 180, IDLE_PCT);
        run_phase(count_t'($urandom_range(200, 10)), count_t'($urandom_range(100, 1)),
                  count_t'($urandom_range(400, 50)), count_t'($urandom_range(150, 1)),
                  sample_t'($urandom_range(SAMPLE_MAX, 0)), 180, IDLE_PCT);

        settle();

        $display("Events accepted: %0d ticks, %0d light samples, %0d flush requests, %0d stops",
                 action_count[ACT_TICK], action_count[ACT_LIGHT], action_count[ACT_FLUSH],
                 action_count[ACT_STOP]);
        $display("%0d resumes and unused codes; %0d snapshots checked over six schedules",
                 action_count[ACT_RESUME] + action_count[ACT_SPARE_LO]
                 + action_count[ACT_SPARE_MID] + action_count[ACT_SPARE_HI],
                 results_checked);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
